FILE: rtl/utf8_to_utf16_escape_decoder_assert.svh
// Assertion macros for the decoder. Each one samples on clk and is
// disabled while rst_n is low; both names must exist where a macro is used.
`ifndef UTF8_TO_UTF16_ESCAPE_DECODER_ASSERT_SVH
`define UTF8_TO_UTF16_ESCAPE_DECODER_ASSERT_SVH

`ifndef SYNTH

`define U8D_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define U8D_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define U8D_ASSERT_IMP(lbl, ante, cons, msg)

`define U8D_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/u8dec_pkg.sv
package u8dec_pkg;

    localparam int CAP_BITS   = 16;
    localparam int UNIT_W     = 21;
    localparam int BYTE_W     = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index, taken from paddr[2].
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_WIDE     = 1'b1;

    localparam logic [CAP_BITS-1:0] CAPACITY_RESET = CAP_BITS'(256);
    localparam logic [CAP_BITS-1:0] CAPACITY_MIN   = CAP_BITS'(3);

    localparam logic [UNIT_W-1:0] ESC_BASE     = 21'h00DC00;
    localparam logic [UNIT_W-1:0] LO_SURR_BASE = 21'h00DC00;
    localparam logic [UNIT_W-1:0] HI_SURR_BASE = 21'h00D800;
    localparam logic [UNIT_W-1:0] SURR_FIRST   = 21'h00D800;
    localparam logic [UNIT_W-1:0] SURR_LAST    = 21'h00DFFF;
    localparam logic [UNIT_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [UNIT_W-1:0] PLANE1_BASE  = 21'h010000;
    localparam logic [UNIT_W-1:0] MIN_TWO      = 21'h000080;
    localparam logic [UNIT_W-1:0] MIN_THREE    = 21'h000800;

    // Sequence length announced by a lead byte; zero for an ASCII byte or
    // for a byte that cannot start a sequence.
    function automatic logic [2:0] lead_length(input logic [BYTE_W-1:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b inside {[8'hC2:8'hDF]})
            len = 3'd2;
        else if (b inside {[8'hE0:8'hEF]})
            len = 3'd3;
        else if (b inside {[8'hF0:8'hF4]})
            len = 3'd4;
        return len;
    endfunction

    function automatic logic [UNIT_W-1:0] cp_four(input logic [BYTE_W-1:0] lead,
                                                  input logic [BYTE_W-1:0] c0,
                                                  input logic [BYTE_W-1:0] c1,
                                                  input logic [BYTE_W-1:0] c2);
        return {lead[2:0], c0[5:0], c1[5:0], c2[5:0]};
    endfunction

endpackage

FILE: rtl/u8dec_in_if.sv
interface u8dec_in_if
    import u8dec_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_req;
    logic              last;

    modport source (output valid, output byte_req, output last, input ready);
    modport sink   (input valid, input byte_req, input last, output ready);
endinterface

FILE: rtl/u8dec_out_if.sv
interface u8dec_out_if
    import u8dec_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [UNIT_W-1:0]   unit;
    logic                end_of_string;
    logic [CAP_BITS-1:0] unit_count;

    modport source (output valid, output unit, output end_of_string, output unit_count,
                    input ready);
    modport sink   (input valid, input unit, input end_of_string, input unit_count,
                    output ready);
endinterface

FILE: rtl/utf8_to_utf16_escape_decoder.sv
// Channel   Direction  Handshake      Payload
// in_ch     in         valid/ready    byte_req[7:0], last
// out_ch    out        valid/ready    unit[20:0], end_of_string, unit_count[15:0]
// APB       in         psel/penable   out_capacity @0x0, wide_units_32 @0x4
//
// A byte passes IDLE, DECIDE and TAIL when it extends a sequence, is a zero or is ignored,
// and LEAD or COMPLETE as well when it starts or completes one; each flushed escape, each
// surrogate half and the end item add a state. All units leave through one result register.
// The sequencer re-arms in_ch.ready only when the byte's work is done.
// A full result register that is not taken stalls the sequencer in place.
// rst_n resets state, counters, output valid and configuration, not the data registers.
`include "utf8_to_utf16_escape_decoder_assert.svh"

module utf8_to_utf16_escape_decoder
    import u8dec_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    u8dec_in_if.sink              in_ch,
    u8dec_out_if.source           out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DECIDE   = 4'd1;
    localparam logic [3:0] ST_COMPLETE = 4'd2;
    localparam logic [3:0] ST_FLUSH    = 4'd3;
    localparam logic [3:0] ST_LEAD     = 4'd4;
    localparam logic [3:0] ST_PAIR_HI  = 4'd5;
    localparam logic [3:0] ST_PAIR_LO  = 4'd6;
    localparam logic [3:0] ST_TAIL     = 4'd7;
    localparam logic [3:0] ST_END      = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [3:0]          after_reg, after_next;
    logic [1:0]          idx_reg, idx_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;
    logic                last_reg, last_next;
    logic [BYTE_W-1:0]   lead_reg, lead_next;
    logic [BYTE_W-1:0]   conts_reg [3];
    logic [BYTE_W-1:0]   conts_next [3];
    logic [2:0]          exp_reg, exp_next;
    logic [1:0]          held_reg, held_next;
    logic [CAP_BITS-1:0] written_reg, written_next;
    logic                halted_reg, halted_next;
    logic [CAP_BITS-1:0] cap_reg;
    logic                wide_reg;

    logic                out_valid_reg;
    logic [UNIT_W-1:0]   out_unit_reg, out_unit_next;
    logic                out_eos_reg, out_eos_next;
    logic [CAP_BITS-1:0] out_count_reg, out_count_next;

    logic                can_load;
    logic                load_out;
    logic                emit_try;
    logic                emit_force;
    logic                emit_go;
    logic                step_ok;
    logic [UNIT_W-1:0]   emit_val;
    logic [CAP_BITS:0]   room_sum;
    logic                room;
    logic [UNIT_W-1:0]   cp;
    logic                cp_ok;
    logic [UNIT_W-1:0]   cp_off;
    logic [1:0]          cont_sel;
    logic                cfg_write;

    // Shared room check: written count plus the units about to go out,
    // against the capacity that keeps one slot for the terminator.
    always_comb
    begin
        room_sum = {1'b0, written_reg}
                 + ((state_reg == ST_PAIR_HI) ? (CAP_BITS+1)'(2) : (CAP_BITS+1)'(1));
        room     = (cap_reg >= CAPACITY_MIN) && (room_sum < {1'b0, cap_reg});
    end

    // Code point of the pending sequence and its range check.
    always_comb
    begin
        case (exp_reg)
            3'd2:
            begin
                cp    = {10'd0, lead_reg[4:0], conts_reg[0][5:0]};
                cp_ok = cp >= MIN_TWO;
            end
            3'd3:
            begin
                cp    = {5'd0, lead_reg[3:0], conts_reg[0][5:0], conts_reg[1][5:0]};
                cp_ok = (cp >= MIN_THREE) && !((cp >= SURR_FIRST) && (cp <= SURR_LAST));
            end
            default:
            begin
                cp    = cp_four(lead_reg, conts_reg[0], conts_reg[1], conts_reg[2]);
                cp_ok = (cp >= PLANE1_BASE) && (cp <= CP_MAX);
            end
        endcase
        cp_off = cp_four(lead_reg, conts_reg[0], conts_reg[1], conts_reg[2]) - PLANE1_BASE;
    end

    assign cont_sel = idx_reg - 2'd1;
    assign can_load = !out_valid_reg || out_ch.ready;
    assign emit_go  = emit_try && (emit_force || (!halted_reg && room));
    assign step_ok  = !(emit_go && !can_load);
    assign load_out = emit_go && can_load;

    always_comb
    begin
        state_next     = state_reg;
        after_next     = after_reg;
        idx_next       = idx_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        lead_next      = lead_reg;
        conts_next     = conts_reg;
        exp_next       = exp_reg;
        held_next      = held_reg;
        written_next   = written_reg;
        halted_next    = halted_reg;
        emit_try       = 1'b0;
        emit_force     = 1'b0;
        emit_val       = '0;
        out_eos_next   = 1'b0;
        out_count_next = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    byte_next  = in_ch.byte_req;
                    last_next  = in_ch.last;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if ((byte_reg != '0) && !halted_reg)
                begin
                    if ((exp_reg != 3'd0) && (byte_reg[7:6] == 2'b10))
                    begin
                        if (held_reg != 2'd3)
                        begin
                            conts_next[held_reg] = byte_reg;
                        end
                        held_next = held_reg + 2'd1;
                        if (({1'b0, held_reg} + 3'd2) >= exp_reg)
                        begin
                            state_next = ST_COMPLETE;
                        end
                        else
                        begin
                            state_next = ST_TAIL;
                        end
                    end
                    else if (exp_reg != 3'd0)
                    begin
                        idx_next   = 2'd0;
                        after_next = ST_LEAD;
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        state_next = ST_LEAD;
                    end
                end
                else
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_COMPLETE:
            begin
                if (!cp_ok)
                begin
                    idx_next   = 2'd0;
                    after_next = ST_TAIL;
                    state_next = ST_FLUSH;
                end
                else if ((exp_reg == 3'd4) && !wide_reg)
                begin
                    state_next = ST_PAIR_HI;
                end
                else
                begin
                    emit_try = 1'b1;
                    emit_val = cp;
                    if (step_ok)
                    begin
                        exp_next   = 3'd0;
                        held_next  = 2'd0;
                        state_next = ST_TAIL;
                    end
                end
            end
            ST_PAIR_HI:
            begin
                emit_try = 1'b1;
                emit_val = HI_SURR_BASE + UNIT_W'(cp_off[19:10]);
                if (step_ok)
                begin
                    if (emit_go)
                    begin
                        state_next = ST_PAIR_LO;
                    end
                    else
                    begin
                        exp_next   = 3'd0;
                        held_next  = 2'd0;
                        state_next = ST_TAIL;
                    end
                end
            end
            ST_PAIR_LO:
            begin
                // Room for both halves was checked with the high half.
                emit_try   = 1'b1;
                emit_force = 1'b1;
                emit_val   = LO_SURR_BASE + UNIT_W'(cp_off[9:0]);
                if (step_ok)
                begin
                    exp_next   = 3'd0;
                    held_next  = 2'd0;
                    state_next = ST_TAIL;
                end
            end
            ST_FLUSH:
            begin
                emit_try = 1'b1;
                if (idx_reg == 2'd0)
                begin
                    emit_val = ESC_BASE + UNIT_W'(lead_reg);
                end
                else
                begin
                    emit_val = ESC_BASE + UNIT_W'(conts_reg[cont_sel]);
                end
                if (step_ok)
                begin
                    if (idx_reg == held_reg)
                    begin
                        exp_next   = 3'd0;
                        held_next  = 2'd0;
                        state_next = after_reg;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            ST_LEAD:
            begin
                if (byte_reg[7] == 1'b0)
                begin
                    emit_try = 1'b1;
                    emit_val = UNIT_W'(byte_reg);
                end
                else if (lead_length(byte_reg) == 3'd0)
                begin
                    emit_try = 1'b1;
                    emit_val = ESC_BASE + UNIT_W'(byte_reg);
                end
                if (step_ok)
                begin
                    exp_next   = lead_length(byte_reg);
                    held_next  = 2'd0;
                    lead_next  = byte_reg;
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                if ((byte_reg == '0) || last_reg)
                begin
                    if (exp_reg != 3'd0)
                    begin
                        idx_next   = 2'd0;
                        after_next = ST_END;
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        state_next = ST_END;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_END:
            begin
                emit_try       = 1'b1;
                emit_force     = 1'b1;
                out_eos_next   = 1'b1;
                out_count_next = written_reg;
                if (step_ok)
                begin
                    written_next = '0;
                    halted_next  = 1'b0;
                    exp_next     = 3'd0;
                    held_next    = 2'd0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A unit that finds no room is dropped and stops the string's output.
        if (emit_try && !emit_force && !halted_reg && !room)
        begin
            halted_next = 1'b1;
        end
        if (load_out && !out_eos_next)
        begin
            written_next = written_reg + CAP_BITS'(1);
        end
        out_unit_next = emit_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            after_reg     <= ST_IDLE;
            idx_reg       <= 2'd0;
            exp_reg       <= 3'd0;
            held_reg      <= 2'd0;
            written_reg   <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            after_reg   <= after_next;
            idx_reg     <= idx_next;
            exp_reg     <= exp_next;
            held_reg    <= held_next;
            written_reg <= written_next;
            halted_reg  <= halted_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        lead_reg  <= lead_next;
        conts_reg <= conts_next;
        if (load_out)
        begin
            out_unit_reg  <= out_unit_next;
            out_eos_reg   <= out_eos_next;
            out_count_reg <= out_count_next;
        end
    end

    // Configuration registers.
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CAPACITY_RESET;
            wide_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_CAPACITY)
            begin
                cap_reg <= pwdata[CAP_BITS-1:0];
            end
            else
            begin
                wide_reg <= pwdata[0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_WIDE)
        begin
            prdata = {{(APB_DATA_W-1){1'b0}}, wide_reg};
        end
        else
        begin
            prdata = {{(APB_DATA_W-CAP_BITS){1'b0}}, cap_reg};
        end
    end

    assign in_ch.ready          = (state_reg == ST_IDLE);
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.unit          = out_unit_reg;
    assign out_ch.end_of_string = out_eos_reg;
    assign out_ch.unit_count    = out_count_reg;

    `U8D_ASSERT_IMP(a_held_idle, exp_reg == 3'd0, held_reg == 2'd0, "held bytes without a lead")
    `U8D_ASSERT_IMP(a_held_bound, exp_reg != 3'd0, {1'b0, held_reg} < exp_reg,
                    "too many held bytes")
    `U8D_ASSERT_NXT(a_end_clears, load_out && out_eos_next,
                    (written_reg == '0) && !halted_reg, "end item did not clear the string state")
    `U8D_ASSERT_IMP(a_no_unit_halted, load_out && !out_eos_next, !halted_reg,
                    "unit written after output stopped")

endmodule

FILE: tb/utf8_to_utf16_escape_decoder_tb.sv
`timescale 1ns / 100ps

module utf8_to_utf16_escape_decoder_tb
    import u8dec_pkg::*;
;

    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 3000;
    localparam int SETTLE_TICKS = 16;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } byte_item_t;

    // Decodes the accepted byte stream on its own and keeps the code units
    // that the block still owes, oldest first.
    class utf8_unit_scoreboard;
        typedef struct {
            logic [UNIT_W-1:0]   unit;
            logic                eos;
            logic [CAP_BITS-1:0] count;
        } unit_rec_t;

        unit_rec_t           expected_units[$];
        int                  mismatches;
        int                  results_seen;
        logic [CAP_BITS-1:0] capacity;
        logic                wide;
        logic [BYTE_W-1:0]   lead;
        logic [BYTE_W-1:0]   conts[3];
        int                  seq_len;
        int                  held;
        logic [CAP_BITS-1:0] written;
        bit                  halted;

        function new();
            mismatches   = 0;
            results_seen = 0;
            capacity     = CAPACITY_RESET;
            wide         = 1'b0;
            lead         = '0;
            conts        = '{default: '0};
            seq_len      = 0;
            held         = 0;
            written      = '0;
            halted       = 1'b0;
        endfunction

        function int outstanding();
            return expected_units.size();
        endfunction

        function void flag_mismatch(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch: %s", $realtime, what);
        endfunction

        function void set_register(logic sel, logic [APB_DATA_W-1:0] value);
            if (sel == REG_CAPACITY)
                capacity = value[CAP_BITS-1:0];
            else
                wide = value[0];
        endfunction

        function void push_rec(logic [UNIT_W-1:0] unit, logic eos, logic [CAP_BITS-1:0] count);
            unit_rec_t rec;
            rec.unit  = unit;
            rec.eos   = eos;
            rec.count = count;
            expected_units.push_back(rec);
        endfunction

        function void put_unit(logic [UNIT_W-1:0] unit);
            if (halted)
                return;
            if (capacity < CAPACITY_MIN || int'(written) + 1 >= int'(capacity)) begin
                halted = 1'b1;
                return;
            end
            push_rec(unit, 1'b0, '0);
            written = written + 1'b1;
        endfunction

        function void put_pair(logic [UNIT_W-1:0] cp);
            logic [UNIT_W-1:0] v;
            if (halted)
                return;
            if (capacity < CAPACITY_MIN || int'(written) + 2 >= int'(capacity)) begin
                halted = 1'b1;
                return;
            end
            v = cp - PLANE1_BASE;
            push_rec(HI_SURR_BASE + (v >> 10), 1'b0, '0);
            push_rec(LO_SURR_BASE + (v & 21'h3FF), 1'b0, '0);
            written = written + 2'd2;
        endfunction

        function void flush_held();
            if (seq_len != 0) begin
                put_unit(ESC_BASE + UNIT_W'(lead));
                for (int k = 0; k < held && k < 3; k++)
                    put_unit(ESC_BASE + UNIT_W'(conts[k]));
            end
            seq_len = 0;
            held    = 0;
        endfunction

        function void start_lead(logic [BYTE_W-1:0] b);
            seq_len = 0;
            held    = 0;
            if (b < 8'h80) begin
                put_unit(UNIT_W'(b));
                return;
            end
            if (b >= 8'hC2 && b <= 8'hDF)
                seq_len = 2;
            else if (b >= 8'hE0 && b <= 8'hEF)
                seq_len = 3;
            else if (b >= 8'hF0 && b <= 8'hF4)
                seq_len = 4;
            else begin
                put_unit(ESC_BASE + UNIT_W'(b));
                return;
            end
            lead = b;
        endfunction

        function void finish_sequence();
            logic [UNIT_W-1:0] cp;
            bit                ok;
            if (seq_len == 2) begin
                cp = UNIT_W'({lead[4:0], conts[0][5:0]});
                ok = cp >= MIN_TWO;
            end else if (seq_len == 3) begin
                cp = UNIT_W'({lead[3:0], conts[0][5:0], conts[1][5:0]});
                ok = cp >= MIN_THREE && !(cp >= SURR_FIRST && cp <= SURR_LAST);
            end else begin
                cp = {lead[2:0], conts[0][5:0], conts[1][5:0], conts[2][5:0]};
                ok = cp >= PLANE1_BASE && cp <= CP_MAX;
            end
            // Overlong, surrogate and out-of-range sequences go out byte by byte.
            if (!ok) begin
                flush_held();
                return;
            end
            if (seq_len == 4 && !wide)
                put_pair(cp);
            else
                put_unit(cp);
            seq_len = 0;
            held    = 0;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b, logic last);
            if (b != 0 && !halted) begin
                if (seq_len != 0 && b[7:6] == 2'b10) begin
                    if (held < 3)
                        conts[held] = b;
                    held++;
                    if (held + 1 >= seq_len)
                        finish_sequence();
                end else begin
                    flush_held();
                    start_lead(b);
                end
            end
            if (b == 0 || last) begin
                flush_held();
                push_rec('0, 1'b1, written);
                written = '0;
                halted  = 1'b0;
                seq_len = 0;
                held    = 0;
            end
        endfunction

        function void check_unit(logic [UNIT_W-1:0] unit, logic eos, logic [CAP_BITS-1:0] count);
            unit_rec_t want;
            results_seen++;
            if (expected_units.size() == 0) begin
                flag_mismatch($sformatf("result %0d not expected: unit=%h eos=%b count=%0d",
                                        results_seen, unit, eos, count));
                return;
            end
            want = expected_units.pop_front();
            if (unit !== want.unit || eos !== want.eos || count !== want.count)
                flag_mismatch($sformatf(
                    "result %0d: expected unit=%h eos=%b count=%0d, got unit=%h eos=%b count=%0d",
                    results_seen, want.unit, want.eos, want.count, unit, eos, count));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    u8dec_in_if  in_ch();
    u8dec_out_if out_ch();

    utf8_unit_scoreboard sb = new();
    byte_item_t          byte_q[$];
    bit                  steady;
    int                  hold_requests = 0;

    utf8_to_utf16_escape_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 clk = ~clk;

    function automatic void push_byte(logic [BYTE_W-1:0] b, logic last = 1'b0);
        byte_item_t item;
        item.value = b;
        item.last  = last;
        byte_q.push_back(item);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_cont();
        return BYTE_W'($urandom_range(8'h80, 8'hBF));
    endfunction

    function automatic void push_codepoint(logic [UNIT_W-1:0] cp);
        if (cp < 21'h80) begin
            push_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            push_byte({3'b110, cp[10:6]});
            push_byte({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            push_byte({4'b1110, cp[15:12]});
            push_byte({2'b10, cp[11:6]});
            push_byte({2'b10, cp[5:0]});
        end else begin
            push_byte({5'b11110, cp[20:18]});
            push_byte({2'b10, cp[17:12]});
            push_byte({2'b10, cp[11:6]});
            push_byte({2'b10, cp[5:0]});
        end
    endfunction

    function automatic void push_well_formed();
        logic [UNIT_W-1:0] cp;
        case ($urandom_range(3))
            0: cp = UNIT_W'($urandom_range(1, 8'h7F));
            1: cp = UNIT_W'($urandom_range(21'h80, 21'h7FF));
            2: begin
                cp = UNIT_W'($urandom_range(21'h800, 21'hFFFF));
                if (cp >= SURR_FIRST && cp <= SURR_LAST)
                    cp = cp ^ 21'h8000;
            end
            default: cp = UNIT_W'($urandom_range(21'h10000, 21'h10FFFF));
        endcase
        push_codepoint(cp);
    endfunction

    function automatic void push_malformed();
        int n_conts;
        case ($urandom_range(5))
            0: begin
                case ($urandom_range(2))
                    0: push_byte(BYTE_W'($urandom_range(8'h80, 8'hBF)));
                    1: push_byte(BYTE_W'($urandom_range(8'hC0, 8'hC1)));
                    default: push_byte(BYTE_W'($urandom_range(8'hF5, 8'hFF)));
                endcase
            end
            1: begin
                // A lead cut short of the continuation bytes that it announces.
                case ($urandom_range(2))
                    0: begin
                        push_byte(BYTE_W'($urandom_range(8'hC2, 8'hDF)));
                        n_conts = 0;
                    end
                    1: begin
                        push_byte(BYTE_W'($urandom_range(8'hE1, 8'hEC)));
                        n_conts = $urandom_range(1);
                    end
                    default: begin
                        push_byte(BYTE_W'($urandom_range(8'hF1, 8'hF3)));
                        n_conts = $urandom_range(2);
                    end
                endcase
                for (int k = 0; k < n_conts; k++)
                    push_byte(rand_cont());
            end
            2: begin
                if ($urandom_range(1)) begin
                    push_byte(8'hE0);
                    push_byte(BYTE_W'($urandom_range(8'h80, 8'h9F)));
                end else begin
                    push_byte(8'hF0);
                    push_byte(BYTE_W'($urandom_range(8'h80, 8'h8F)));
                    push_byte(rand_cont());
                end
                push_byte(rand_cont());
            end
            3: begin
                push_byte(8'hED);
                push_byte(BYTE_W'($urandom_range(8'hA0, 8'hBF)));
                push_byte(rand_cont());
            end
            4: begin
                push_byte(8'hF4);
                push_byte(BYTE_W'($urandom_range(8'h90, 8'hBF)));
                push_byte(rand_cont());
                push_byte(rand_cont());
            end
            default: push_byte(BYTE_W'($urandom_range(1, 8'hFF)));
        endcase
    endfunction

    function automatic void build_strings(int n_items);
        int pieces;
        while (byte_q.size() < n_items) begin
            if ($urandom_range(9) == 0) begin
                push_byte(8'h00, 1'($urandom_range(1)));
                continue;
            end
            pieces = $urandom_range(1, 12);
            for (int p = 0; p < pieces; p++) begin
                if ($urandom_range(99) < 70)
                    push_well_formed();
                else
                    push_malformed();
            end
            case ($urandom_range(3))
                0, 1: byte_q[byte_q.size()-1].last = 1'b1;
                2: push_byte(8'h00, 1'b0);
                default: push_byte(8'h00, 1'b1);
            endcase
        end
    endfunction

    function automatic void build_opening();
        push_byte(8'h00, 1'b1);
        push_byte(8'h7F);
        push_byte(8'hC2); push_byte(8'h80);
        push_byte(8'hEF); push_byte(8'hBF); push_byte(8'hBF);
        push_byte(8'hF4); push_byte(8'h8F); push_byte(8'hBF); push_byte(8'hBF);
        push_byte(8'h80);
        push_byte(8'hC0);
        push_byte(8'hF5);
        push_byte(8'hE0); push_byte(8'h80); push_byte(8'h80);
        push_byte(8'hED); push_byte(8'hA0); push_byte(8'h80);
        push_byte(8'hF4); push_byte(8'h90); push_byte(8'h80); push_byte(8'h80);
        push_byte(8'hC3); push_byte(8'h41);
        // The string ends with a sequence still open.
        push_byte(8'hE2); push_byte(8'h82, 1'b1);
    endfunction

    task automatic reg_write(logic sel, logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] stored;
        if (sel == REG_CAPACITY)
            stored = APB_DATA_W'(value[CAP_BITS-1:0]);
        else
            stored = APB_DATA_W'(value[0]);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_register(sel, value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== stored)
            sb.flag_mismatch($sformatf("register %0d read back %h, expected %h",
                                       sel, prdata, stored));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_bytes();
        int idx;
        idx = 0;
        while (idx < byte_q.size()) begin
            @(posedge clk);
            if (in_ch.valid && in_ch.ready) begin
                sb.note_byte(byte_q[idx].value, byte_q[idx].last);
                idx++;
            end
            if (in_ch.valid && !in_ch.ready) begin
                // The offered byte stays on the bus until its transfer.
            end else if (idx < byte_q.size() && (steady || $urandom_range(99) >= 25)) begin
                in_ch.valid    <= 1'b1;
                in_ch.byte_req <= byte_q[idx].value;
                in_ch.last     <= byte_q[idx].last;
            end else begin
                in_ch.valid    <= 1'b0;
            end
        end
    endtask

    // The block may still be chewing on a byte that produces nothing.
    task automatic settle();
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic run_phase(logic [CAP_BITS-1:0] capacity, logic wide, int n_items,
                             bit calm, bit squeeze);
        settle();
        reg_write(REG_CAPACITY, APB_DATA_W'(capacity));
        reg_write(REG_WIDE, APB_DATA_W'(wide));
        byte_q.delete();
        build_strings(n_items);
        steady = calm;
        if (squeeze)
            hold_requests++;
        send_bytes();
        steady = 1'b0;
    endtask

    initial begin : receiver
        int hold_left;
        int holds_taken;
        hold_left    = 0;
        holds_taken  = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                sb.check_unit(out_ch.unit, out_ch.end_of_string, out_ch.unit_count);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (holds_taken != hold_requests) begin
                holds_taken  = hold_requests;
                hold_left    = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= steady || ($urandom_range(99) >= 25);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.byte_req = '0;
        in_ch.last     = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        steady         = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values first: capacity of 256 and surrogate pairs.
        build_opening();
        send_bytes();

        run_phase(16'hFFFF, 1'b1, 60, 1'b1, 1'b0);
        run_phase(16'd0, 1'b0, 20, 1'b0, 1'b0);
        run_phase(16'd3, 1'b0, 40, 1'b0, 1'b0);
        run_phase(CAP_BITS'($urandom_range(4, 24)), 1'b1, 60, 1'b0, 1'b1);
        run_phase(CAP_BITS'($urandom_range(4, 40)), 1'b0, 80, 1'b0, 1'b0);
        run_phase(16'd2, 1'b1, 20, 1'b0, 1'b0);
        run_phase(16'hFFFF, 1'b0, 80, 1'b0, 1'b0);
        run_phase(CAP_BITS'($urandom_range(3, 16'hFFFF)), 1'($urandom_range(1)), 60,
                  1'b0, 1'b0);

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
